// ===== sv/iq4x_pkg.sv =====
package iq4x_pkg;

  localparam int unsigned LastPos    = 135;
  localparam int unsigned FirstWtPos = 8;
  localparam logic [15:0] HalfNan    = 16'h7E00;
  localparam logic [14:0] HalfInf    = 15'h7C00;

  // IQ4_NL codebook magnitude; the sign is taken from ~nib[3] by the caller
  function automatic logic [6:0] kv_mag(input logic [3:0] nib);
    case (nib)
      4'd0:    kv_mag = 7'd127;
      4'd1:    kv_mag = 7'd104;
      4'd2:    kv_mag = 7'd83;
      4'd3:    kv_mag = 7'd65;
      4'd4:    kv_mag = 7'd49;
      4'd5:    kv_mag = 7'd35;
      4'd6:    kv_mag = 7'd22;
      4'd7:    kv_mag = 7'd10;
      4'd8:    kv_mag = 7'd1;
      4'd9:    kv_mag = 7'd13;
      4'd10:   kv_mag = 7'd25;
      4'd11:   kv_mag = 7'd38;
      4'd12:   kv_mag = 7'd53;
      4'd13:   kv_mag = 7'd69;
      4'd14:   kv_mag = 7'd89;
      default: kv_mag = 7'd113;
    endcase
  endfunction

  // Work handed to the conversion unit
  typedef struct packed {
    logic        sign;
    logic [10:0] m;      // significand incl. hidden bit
    logic [4:0]  ef;     // biased exponent field
    logic        fr_nz;
    logic [5:0]  als;    // |ls-32|
    logic [3:0]  nib;
  } cvt_req_t;

endpackage

// ===== sv/iq4x_cvt.sv =====
// Multi-cycle product + round to fp16: m*|ls| is registered in p1_q at start,
// then *|kv| in p2_q, then leading-one and round into res_q.
module iq4x_cvt import iq4x_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  cvt_req_t    req_i,
  output logic        done_o,
  output logic [15:0] res_o
);

  logic [1:0]  step_q, step_d;
  cvt_req_t    req_q;
  logic [16:0] p1_q;
  logic [23:0] p2_q;
  logic [15:0] res_q, res_d;
  logic        done_q;

  // rounding of p2_q * 2^ex
  logic [4:0]  lz;
  logic signed [7:0] ex, q, s;
  logic [23:0] r, rem, halfv, mask;
  logic [16:0] bits;
  logic        up;

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (p2_q[i]) lz = 5'(i);
    end
  end

  always_comb begin
    ex = (req_q.ef == 5'd0) ? -8'sd24 : ($signed({3'b000, req_q.ef}) - 8'sd25);
    q  = $signed({3'b000, lz}) + ex - 8'sd10;
    if (q < -8'sd24) q = -8'sd24;
    s = q - ex;
    r = '0; rem = '0; halfv = '0; mask = '0; up = 1'b0;
    if (s <= 0) begin
      r = p2_q << (-s);
    end else begin
      mask  = (24'd1 << s) - 24'd1;
      halfv = 24'd1 << (s - 8'sd1);
      rem   = p2_q & mask;
      r     = p2_q >> s;
      up    = (rem > halfv) || ((rem == halfv) && r[0]);
    end
    bits = 17'((q + 8'sd24)) * 17'd1024 + 17'(r) + 17'(up);
    if (req_q.ef == 5'd31) begin
      res_d = (req_q.fr_nz || req_q.als == 6'd0) ? HalfNan : {req_q.sign, HalfInf};
    end else if (p2_q == '0) begin
      res_d = {req_q.sign, 15'd0};
    end else if (bits >= 17'h7C00) begin
      res_d = {req_q.sign, HalfInf};
    end else begin
      res_d = {req_q.sign, bits[14:0]};
    end
  end

  always_comb begin
    step_d = step_q;
    if (start_i)             step_d = 2'd1;
    else if (step_q != 2'd0) step_d = step_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= (step_q == 2'd3);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      req_q <= req_i;
      p1_q  <= req_i.m * req_i.als;
    end
    if (step_q == 2'd1) p2_q <= p1_q * kv_mag(req_q.nib);
    if (step_q == 2'd3) res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== sv/iq4_xs_block_dequantizer.sv =====
// IQ4_XS dequantizer: takes 136-byte super-blocks one byte per transfer and
// emits 256 fp16 weights each (low nibble weight, then high nibble weight).
// Header bytes 0..7 give no output and leave the block ready. For each data
// byte, one shared multiply/round unit converts the low and then the high
// nibble weight; each weight is held in the output register until the
// receiver takes it, and only after the high nibble weight is taken does the
// block return to idle. It is not ready during that time, so output stalls
// hold off the next byte.
module iq4_xs_block_dequantizer import iq4x_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [15:0] weight_bits_o,
  output logic [7:0]  weight_index_o,
  output logic        last_of_block_o
);

  typedef enum logic [2:0] {IDLE, CVT_LO, OUT_LO, CVT_HI, OUT_HI} state_e;

  state_e      state_q;
  logic [7:0]  pos_q;
  logic [15:0] scale_q, hsb_q;
  logic [31:0] lsn_q;
  logic [7:0]  byte_q, idx_q;
  logic [2:0]  sub_q;
  logic        valid_q;
  logic [15:0] wbits_q;
  logic        start;
  cvt_req_t    req;
  logic        cvt_done;
  logic [15:0] cvt_res;

  logic [7:0] pos, j;
  logic [2:0] sub;
  logic [5:0] ls;
  logic       ls_neg;
  logic [3:0] nib;

  assign pos = (pos_q > 8'(LastPos)) ? 8'd0 : pos_q;
  assign j   = pos - 8'(FirstWtPos);

  // low-nibble start happens in IDLE on the byte being accepted, so take
  // its fields straight from the input; the high-nibble start uses byte_q
  always_comb begin
    sub    = (state_q == IDLE) ? j[6:4] : sub_q;
    ls     = {hsb_q[2*sub +: 2], lsn_q[4*sub +: 4]};
    ls_neg = ~ls[5];
    nib    = (state_q == IDLE)   ? data_byte_i[3:0] :
             (state_q == OUT_LO) ? byte_q[7:4] : byte_q[3:0];
    req.sign  = scale_q[15] ^ ls_neg ^ ~nib[3];
    req.ef    = scale_q[14:10];
    req.fr_nz = |scale_q[9:0];
    req.m     = {|scale_q[14:10], scale_q[9:0]};
    req.als   = ls_neg ? 6'(6'd32 - ls) : 6'(ls - 6'd32);
    req.nib   = nib;
  end

  assign ready_o = (state_q == IDLE);
  assign start   = (valid_i && ready_o && pos >= 8'(FirstWtPos))
                 || (state_q == OUT_LO && valid_q && ready_i);

  iq4x_cvt u_cvt (
    .clk_i, .rst_ni, .start_i(start), .req_i(req),
    .done_o(cvt_done), .res_o(cvt_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      pos_q   <= '0;
      scale_q <= '0;
      hsb_q   <= '0;
      lsn_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        IDLE: if (valid_i) begin
          pos_q <= (pos == 8'(LastPos)) ? 8'd0 : pos + 8'd1;
          if (pos == 8'd0) scale_q[7:0] <= data_byte_i;
          else if (pos == 8'd1) scale_q[15:8] <= data_byte_i;
          else if (pos == 8'd2) hsb_q[7:0] <= data_byte_i;
          else if (pos == 8'd3) hsb_q[15:8] <= data_byte_i;
          else if (pos < 8'(FirstWtPos)) lsn_q[8*pos[1:0] +: 8] <= data_byte_i;
          else state_q <= CVT_LO;
        end
        CVT_LO: if (cvt_done) begin
          valid_q <= 1'b1;
          state_q <= OUT_LO;
        end
        OUT_LO: if (ready_i) begin
          valid_q <= 1'b0;
          state_q <= CVT_HI;
        end
        CVT_HI: if (cvt_done) begin
          valid_q <= 1'b1;
          state_q <= OUT_HI;
        end
        OUT_HI: if (ready_i) begin
          valid_q <= 1'b0;
          state_q <= IDLE;
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  // byte fields kept for the high-nibble weight and the output index
  always_ff @(posedge clk_i) begin
    if (state_q == IDLE && valid_i) begin
      byte_q <= data_byte_i;
      sub_q  <= j[6:4];
      idx_q  <= {j[6:4], 1'b0, j[3:0]};
    end
    if (state_q == OUT_LO && ready_i) idx_q <= idx_q + 8'd16;
    if (cvt_done) wbits_q <= cvt_res;
  end

  assign valid_o         = valid_q;
  assign weight_bits_o   = wbits_q;
  assign weight_index_o  = idx_q;
  assign last_of_block_o = (state_q == OUT_HI) && (idx_q == 8'd255);

  property p_not_ready_busy;
    @(posedge clk_i) disable iff (!rst_ni) valid_o |-> !ready_o;
  endproperty
  assert property (p_not_ready_busy) else $error("ready while output pending");

  property p_pos_range;
    @(posedge clk_i) disable iff (!rst_ni) pos_q <= 8'(LastPos);
  endproperty
  assert property (p_pos_range) else $error("byte position out of range");

  property p_last_hi;
    @(posedge clk_i) disable iff (!rst_ni) last_of_block_o |-> valid_o;
  endproperty
  assert property (p_last_hi) else $error("last flag without valid");

endmodule
